[design/dme_pkg.sv]
`timescale 1ns / 1ps

package dme_pkg;

  // Contents of one map cell.
  typedef enum logic [1:0] {
    CELL_UNKNOWN = 2'd0,
    CELL_VISITED = 2'd1,
    CELL_WALL    = 2'd2
  } cell_t;

  // Direction codes, also the bit positions in the open-directions field.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Move kinds reported with each result item.
  localparam logic [1:0] MOVE_NONE      = 2'd0;
  localparam logic [1:0] MOVE_ADVANCE   = 2'd1;
  localparam logic [1:0] MOVE_BACKTRACK = 2'd2;

  // A frame on the stack: untried direction count and arrival direction.
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] arr;
  } frame_t;

  // Untried count of a freshly pushed frame.
  localparam logic [1:0] FRESH_CNT = 2'd3;

endpackage

[design/dme_cell_map.sv]
`timescale 1ns / 1ps

module dme_cell_map #(
  parameter int CELLS  = 961,
  parameter int CENTER = 480,
  parameter int AW     = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output dme_pkg::cell_t  rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  dme_pkg::cell_t  wr_data,
  output logic            busy
);

  dme_pkg::cell_t mem [CELLS];
  dme_pkg::cell_t rd_data_r;
  logic [AW-1:0]  clr_idx_r;
  logic           busy_r;

  // Clearing sweep after reset: one cell a cycle. The start cell is written as
  // visited, since the mouse stands there before the first item arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      if (clr_idx_r == AW'(CELLS - 1)) begin
        busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  // Single write port shared between the sweep and the explorer.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= (clr_idx_r == AW'(CENTER)) ? dme_pkg::CELL_VISITED
                                                   : dme_pkg::CELL_UNKNOWN;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

[design/dme_frame_ram.sv]
`timescale 1ns / 1ps

module dme_frame_ram #(
  parameter int DEPTH = 961,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output dme_pkg::frame_t  rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  dme_pkg::frame_t  wr_data
);

  dme_pkg::frame_t mem [DEPTH];
  dme_pkg::frame_t rd_data_r;

  // Frames below the top of the stack; the top frame lives in a register.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/dfs_maze_explorer_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_cheese_found, in_open_dirs
// out_      output     out_valid/out_stall  out_pos_x, out_pos_y, out_found,
//                                           out_move_kind, out_move_dir,
//                                           out_finished, out_error
//
// Each item has an accept cycle, which reads the neighbour cell when trying a
// direction and the frame below the top when backing up, and a write-back
// cycle, which writes the map and the stack and loads the result register. A
// new item is taken only once the last one has been written back. After reset
// the map is swept clear, one cell a cycle, while in_stall is high.
// While out_stall holds a result in the output register, the next item waits
// in its write-back cycle and in_stall stays high until that result is taken.

module dfs_maze_explorer_top #(
  parameter int MAX_DIM = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cheese_found,
  input  logic [3:0]        in_open_dirs,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [4:0] out_pos_x,
  output logic signed [4:0] out_pos_y,
  output logic              out_found,
  output logic [1:0]        out_move_kind,
  output logic [1:0]        out_move_dir,
  output logic              out_finished,
  output logic              out_error
);

  localparam int GRID_W = 2 * MAX_DIM + 1;
  localparam int CELLS  = GRID_W * GRID_W;
  localparam int CENTER = MAX_DIM * GRID_W + MAX_DIM;
  localparam int AW     = $clog2(CELLS);
  localparam int DW     = $clog2(CELLS + 2);
  localparam int POS_W  = $clog2(MAX_DIM + 2) + 1;

  localparam logic [AW-1:0]           ROW_STEP = AW'(GRID_W);
  localparam logic signed [POS_W-1:0] POS_MAX  = POS_W'(MAX_DIM);
  localparam logic signed [POS_W-1:0] POS_MIN  = -POS_MAX;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TRY,
    OP_ROOT_END,
    OP_BACK,
    OP_ERR
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Architectural state.
  state_t                  st_r;
  logic [DW-1:0]           depth_r;
  logic [2:0]              root_untried_r;
  dme_pkg::frame_t         top_r;
  logic signed [POS_W-1:0] cur_x_r;
  logic signed [POS_W-1:0] cur_y_r;
  logic [AW-1:0]           cur_idx_r;

  // Item in flight between the accept and write-back cycles.
  op_t                     op_r;
  logic                    found_r;
  logic [1:0]              dir_r;
  logic                    open_r;
  logic                    inmap_r;
  logic [AW-1:0]           nidx_r;
  logic signed [POS_W-1:0] nx_r;
  logic signed [POS_W-1:0] ny_r;

  // Result register.
  logic                    out_valid_r;
  logic signed [4:0]       pos_x_r;
  logic signed [4:0]       pos_y_r;
  logic                    found_out_r;
  logic [1:0]              kind_r;
  logic [1:0]              mdir_r;
  logic                    finished_r;
  logic                    error_r;

  // Memory ports.
  dme_pkg::cell_t          map_rd;
  dme_pkg::cell_t          map_wr_data;
  logic                    map_wr_en;
  logic                    map_busy;
  dme_pkg::frame_t         stk_rd;
  logic                    stk_rd_en;
  logic                    stk_wr_en;
  logic [AW-1:0]           stk_rd_addr;
  logic [AW-1:0]           stk_wr_addr;

  // Decode signals of the accept cycle.
  logic                    in_acc;
  logic                    is_empty;
  logic                    is_root;
  logic [2:0]              cnt;
  logic [1:0]              side_a;
  logic [1:0]              side_b;
  logic [1:0]              side_hi;
  logic [1:0]              side_lo;
  logic [1:0]              try_dir;
  logic [1:0]              back_dir;
  logic [1:0]              sel_dir;
  logic signed [POS_W-1:0] nx;
  logic signed [POS_W-1:0] ny;
  logic [AW-1:0]           nidx;
  logic                    inmap;
  op_t                     op;

  // Decode signals of the write-back cycle.
  logic                    out_free;
  logic                    fire;
  logic                    nbr_free;
  logic                    room;
  logic                    do_adv;
  logic                    do_wall;
  logic                    do_back;
  logic [DW-1:0]           depth_nxt;
  logic signed [POS_W-1:0] x_nxt;
  logic signed [POS_W-1:0] y_nxt;
  logic [AW-1:0]           idx_nxt;
  logic [1:0]              kind_nxt;

  assign in_stall = (st_r != S_IDLE) || map_busy;
  assign in_acc   = in_valid && !in_stall;

  // Pick the direction to try or the way back, and locate that neighbour.
  always_comb begin
    is_empty = (depth_r == '0);
    is_root  = (depth_r == DW'(1));
    cnt      = is_root ? root_untried_r : {1'b0, top_r.cnt};
    side_a   = top_r.arr + 2'd1;
    side_b   = top_r.arr + 2'd3;
    side_hi  = (side_a > side_b) ? side_a : side_b;
    side_lo  = (side_a > side_b) ? side_b : side_a;
    if (is_root) begin
      try_dir = 2'(cnt - 3'd1);
    end else begin
      case (top_r.cnt)
        2'd3:    try_dir = top_r.arr;
        2'd2:    try_dir = side_hi;
        default: try_dir = side_lo;
      endcase
    end
    back_dir = top_r.arr + 2'd2;
    sel_dir  = (cnt == 3'd0) ? back_dir : try_dir;

    nx   = cur_x_r;
    ny   = cur_y_r;
    nidx = cur_idx_r;
    case (sel_dir)
      dme_pkg::DIR_UP: begin
        ny   = cur_y_r - POS_W'(1);
        nidx = cur_idx_r - ROW_STEP;
      end
      dme_pkg::DIR_LEFT: begin
        nx   = cur_x_r - POS_W'(1);
        nidx = cur_idx_r - AW'(1);
      end
      dme_pkg::DIR_DOWN: begin
        ny   = cur_y_r + POS_W'(1);
        nidx = cur_idx_r + ROW_STEP;
      end
      default: begin
        nx   = cur_x_r + POS_W'(1);
        nidx = cur_idx_r + AW'(1);
      end
    endcase
    inmap = (nx >= POS_MIN) && (nx <= POS_MAX) && (ny >= POS_MIN) && (ny <= POS_MAX);

    if (in_cheese_found || is_empty) begin
      op = OP_NONE;
    end else if (cnt != 3'd0) begin
      op = OP_TRY;
    end else if (is_root) begin
      op = OP_ROOT_END;
    end else if (in_open_dirs[sel_dir] && inmap) begin
      op = OP_BACK;
    end else begin
      op = OP_ERR;
    end
  end

  // Frame below the top is fetched when backing up onto a non-root frame.
  assign stk_rd_en   = in_acc && (op == OP_BACK) && (depth_r >= DW'(3));
  assign stk_rd_addr = AW'(depth_r - DW'(3));

  // Write-back decisions once the neighbour cell has been read.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    fire     = (st_r == S_EXEC) && out_free;
    nbr_free = inmap_r && (map_rd == dme_pkg::CELL_UNKNOWN);
    room     = (depth_r <= DW'(CELLS));
    do_adv   = (op_r == OP_TRY) && nbr_free && open_r && room;
    do_wall  = (op_r == OP_TRY) && nbr_free && !open_r;
    do_back  = (op_r == OP_BACK);

    depth_nxt = depth_r;
    x_nxt     = cur_x_r;
    y_nxt     = cur_y_r;
    idx_nxt   = cur_idx_r;
    kind_nxt  = dme_pkg::MOVE_NONE;
    if (do_adv || do_back) begin
      depth_nxt = do_adv ? depth_r + DW'(1) : depth_r - DW'(1);
      x_nxt     = nx_r;
      y_nxt     = ny_r;
      idx_nxt   = nidx_r;
      kind_nxt  = do_adv ? dme_pkg::MOVE_ADVANCE : dme_pkg::MOVE_BACKTRACK;
    end else if (op_r == OP_ROOT_END) begin
      depth_nxt = '0;
    end

    map_wr_en   = fire && (do_adv || do_wall);
    map_wr_data = do_adv ? dme_pkg::CELL_VISITED : dme_pkg::CELL_WALL;
    stk_wr_en   = fire && do_adv && (depth_r >= DW'(2));
    stk_wr_addr = AW'(depth_r - DW'(2));
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= S_IDLE;
      depth_r        <= DW'(1);
      root_untried_r <= 3'd4;
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      cur_idx_r      <= AW'(CENTER);
    end else if (in_acc) begin
      st_r <= S_EXEC;
      // The tried direction is used up whatever the map says.
      if (op == OP_TRY) begin
        if (is_root) begin
          root_untried_r <= cnt - 3'd1;
        end else begin
          top_r.cnt <= top_r.cnt - 2'd1;
        end
      end
    end else if (fire) begin
      st_r      <= S_IDLE;
      depth_r   <= depth_nxt;
      cur_x_r   <= x_nxt;
      cur_y_r   <= y_nxt;
      cur_idx_r <= idx_nxt;
      if (do_adv) begin
        top_r <= '{cnt: dme_pkg::FRESH_CNT, arr: dir_r};
      end else if (do_back && (depth_r >= DW'(3))) begin
        top_r <= stk_rd;
      end
    end
  end

  // Item in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= op;
      found_r <= in_cheese_found;
      dir_r   <= sel_dir;
      open_r  <= in_open_dirs[sel_dir];
      inmap_r <= inmap;
      nidx_r  <= nidx;
      nx_r    <= nx;
      ny_r    <= ny;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos_x_r     <= 5'(32'(x_nxt));
      pos_y_r     <= 5'(32'(y_nxt));
      found_out_r <= found_r;
      kind_r      <= kind_nxt;
      mdir_r      <= (kind_nxt == dme_pkg::MOVE_NONE) ? dme_pkg::DIR_UP : dir_r;
      finished_r  <= (depth_nxt == '0);
      error_r     <= (op_r == OP_ERR);
    end
  end

  dme_cell_map #(
    .CELLS  (CELLS),
    .CENTER (CENTER),
    .AW     (AW)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc && (op == OP_TRY)),
    .rd_addr (nidx),
    .rd_data (map_rd),
    .wr_en   (map_wr_en),
    .wr_addr (nidx_r),
    .wr_data (map_wr_data),
    .busy    (map_busy)
  );

  dme_frame_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (top_r)
  );

  assign out_valid     = out_valid_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_found     = found_out_r;
  assign out_move_kind = kind_r;
  assign out_move_dir  = mdir_r;
  assign out_finished  = finished_r;
  assign out_error     = error_r;

endmodule
